// ===== hw/rtl/button_press_classifier_assert.svh =====
// Assertion macros for the button press classifier.
// Every macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The condition must hold in every cycle outside reset.
`define BPC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

	// Switch bank geometry.
	localparam int NUM_SWITCHES = 3;
	localparam int LEVEL_W      = 3;
	localparam int SCAN_N       = (NUM_SWITCHES < LEVEL_W) ? NUM_SWITCHES : LEVEL_W;
	localparam int SWITCH_W     = 2;

	// Field and register widths.
	localparam int KIND_W     = 2;
	localparam int PHASE_W    = 3;
	localparam int CNT_W      = 8;
	localparam int LIMIT_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Limit values after reset.
	localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST = 8'd5;
	localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST     = 8'd75;
	localparam logic [CNT_W-1:0]   CNT_MAX            = '1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE_LIMIT = 1'b0,
		CFG_HOLD_LIMIT     = 1'b1
	} cfg_idx_t;

	// Reported event codes.
	typedef enum logic [KIND_W-1:0] {
		EV_NONE       = 2'd0,
		EV_SHORT      = 2'd1,
		EV_HOLD_START = 2'd2,
		EV_HOLD_END   = 2'd3
	} ev_kind_t;

	// Phase codes as they appear on the result channel.
	localparam logic [PHASE_W-1:0] PHASE_IDLE     = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_DEBOUNCE = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_WAIT     = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_HOLD     = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_PROC     = 3'd4;

	// Internal one-hot phase state.
	typedef enum logic [4:0] {
		PH_IDLE     = 5'b00001,
		PH_DEBOUNCE = 5'b00010,
		PH_WAIT     = 5'b00100,
		PH_HOLD     = 5'b01000,
		PH_PROC     = 5'b10000
	} phase_t;

	// Map the one-hot state to its external code.
	function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_W-1:0] code;
		case (ph)
			PH_DEBOUNCE: code = PHASE_DEBOUNCE;
			PH_WAIT:     code = PHASE_WAIT;
			PH_HOLD:     code = PHASE_HOLD;
			PH_PROC:     code = PHASE_PROC;
			default:     code = PHASE_IDLE;
		endcase
		return code;
	endfunction

endpackage

// ===== hw/rtl/bpc_in_if.sv =====
interface bpc_in_if;

	logic                         valid;
	logic                         ready;
	logic [bpc_pkg::LEVEL_W-1:0]  switch_levels;

	modport source (output valid, output switch_levels, input ready);
	modport sink   (input valid, input switch_levels, output ready);

endinterface

// ===== hw/rtl/bpc_out_if.sv =====
interface bpc_out_if;

	logic                         valid;
	logic                         ready;
	logic [bpc_pkg::KIND_W-1:0]   event_kind;
	logic [bpc_pkg::SWITCH_W-1:0] event_switch;
	logic [bpc_pkg::PHASE_W-1:0]  phase;

	modport source (output valid, output event_kind, output event_switch, output phase,
		input ready);
	modport sink   (input valid, input event_kind, input event_switch, input phase,
		output ready);

endinterface

// ===== hw/rtl/button_press_classifier.sv =====
// Button press classifier: debounces a small bank of active-low switches and
// reports short presses, the start of a long hold and the release after a hold.
// Channels: in_ch carries one poll tick per beat (switch_levels, 0 = pressed);
// out_ch returns exactly one beat per tick with event_kind, event_switch and
// the phase after that tick. Both use valid/ready; a beat moves when both are high.
// Configuration: cfg_we writes cfg_wdata into the limit selected by cfg_index
// (0 debounce limit, 1 hold limit); write only while no tick is in flight.
// Result: registered; on out_ch in the cycle after the tick is accepted.
// Throughput: one tick per cycle while out_ch takes each result; the whole phase
// update is one level of logic between the state registers and the result register.
// Stalls: in_ch stays ready while the result register is empty or is being
// drained in the same cycle; a stalled receiver holds the result and the block
// takes no new tick until it moves.
// Reset: the machine returns to idle with switch 0 tracked, the press counter
// cleared, the limits at 5 and 75 and the result register empty.
`include "button_press_classifier_assert.svh"

module button_press_classifier (
	input  logic                                clk,
	input  logic                                arst_n,
	bpc_in_if.sink                              in_ch,
	bpc_out_if.source                           out_ch,
	input  logic                                cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	logic [bpc_pkg::LIMIT_W-1:0]  debounce_limit_q;
	logic [bpc_pkg::LIMIT_W-1:0]  hold_limit_q;
	bpc_pkg::phase_t              phase_q, phase_d;
	logic [bpc_pkg::SWITCH_W-1:0] tracked_q, tracked_d;
	logic [bpc_pkg::CNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
	bpc_pkg::ev_kind_t            ev_d;
	logic                         down;
	logic                         accept;
	logic                         out_valid_q;
	logic [bpc_pkg::KIND_W-1:0]   kind_q;
	logic [bpc_pkg::SWITCH_W-1:0] switch_q;
	logic [bpc_pkg::PHASE_W-1:0]  phase_out_q;

	// Handshake: accept whenever the result register is free or draining.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_limit_q <= bpc_pkg::DEBOUNCE_LIMIT_RST;
			hold_limit_q     <= bpc_pkg::HOLD_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bpc_pkg::CFG_DEBOUNCE_LIMIT: debounce_limit_q <= cfg_wdata;
				bpc_pkg::CFG_HOLD_LIMIT:     hold_limit_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Tracked switch level; an index past the bank reads as released.
	always_comb begin
		down = 1'b0;
		for (int i = 0; i < bpc_pkg::LEVEL_W; i++) begin
			if (tracked_q == bpc_pkg::SWITCH_W'(i)) begin
				down = !in_ch.switch_levels[i];
			end
		end
	end

	// Saturating press counter increment.
	assign cnt_inc = (cnt_q == bpc_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	// Next-state logic for one poll tick.
	always_comb begin
		phase_d   = phase_q;
		tracked_d = tracked_q;
		cnt_d     = cnt_q;
		ev_d      = bpc_pkg::EV_NONE;
		case (phase_q)
			bpc_pkg::PH_DEBOUNCE: begin
				cnt_d = cnt_inc;
				if (cnt_inc > debounce_limit_q) begin
					phase_d = down ? bpc_pkg::PH_WAIT : bpc_pkg::PH_IDLE;
				end
			end
			bpc_pkg::PH_WAIT: begin
				if (down) begin
					cnt_d = cnt_inc;
					if (cnt_inc > hold_limit_q) begin
						phase_d = bpc_pkg::PH_HOLD;
						ev_d    = bpc_pkg::EV_HOLD_START;
					end
				end else begin
					phase_d = bpc_pkg::PH_PROC;
				end
			end
			bpc_pkg::PH_HOLD: begin
				if (down) begin
					cnt_d = cnt_inc;
				end else begin
					phase_d = bpc_pkg::PH_IDLE;
					ev_d    = bpc_pkg::EV_HOLD_END;
				end
			end
			bpc_pkg::PH_PROC: begin
				phase_d = bpc_pkg::PH_IDLE;
				ev_d    = bpc_pkg::EV_SHORT;
			end
			default: begin
				// Idle: the lowest-numbered pressed switch wins, so scan from the top down.
				phase_d = bpc_pkg::PH_IDLE;
				for (int i = bpc_pkg::SCAN_N - 1; i >= 0; i--) begin
					if (!in_ch.switch_levels[i]) begin
						tracked_d = bpc_pkg::SWITCH_W'(i);
						cnt_d     = '0;
						phase_d   = bpc_pkg::PH_DEBOUNCE;
					end
				end
			end
		endcase
	end

	// Machine state advances on each accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bpc_pkg::PH_IDLE;
			tracked_q <= '0;
			cnt_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			tracked_q <= tracked_d;
			cnt_q     <= cnt_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q      <= ev_d;
			switch_q    <= tracked_d;
			phase_out_q <= bpc_pkg::phase_code(phase_d);
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.event_kind   = kind_q;
	assign out_ch.event_switch = switch_q;
	assign out_ch.phase        = phase_out_q;

	// Checks on the machine and the result register.
	`BPC_ASSERT_ALWAYS(a_phase_onehot, $onehot(phase_q), "phase state is not one-hot")
	`BPC_ASSERT_IMP(a_hold_start_phase,
		out_valid_q && (kind_q == bpc_pkg::EV_HOLD_START), phase_out_q == bpc_pkg::PHASE_HOLD,
		"hold start reported outside the holding phase")
	`BPC_ASSERT_IMP(a_short_goes_idle,
		out_valid_q && (kind_q == bpc_pkg::EV_SHORT), phase_out_q == bpc_pkg::PHASE_IDLE,
		"short press reported without return to idle")
	`BPC_ASSERT_NEXT(a_accept_fills, accept, out_valid_q && (phase_out_q == bpc_pkg::phase_code(phase_q)),
		"accepted tick did not load the result register")

endmodule
